// ===== src/assert_macros.svh =====
// assertion macros shared by the vector normalize rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define VN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define VN_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define VN_ASSERT(lbl, clk, rstn, prop)
`define VN_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ===== src/vn_pkg.sv =====
// types, constants and single precision helpers for the vector normalize block
// no dependencies
`default_nettype none

package vn_pkg;

  typedef struct packed {
    logic [2:0]  vec_size;
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
    logic [31:0] comp_w;
  } vn_in_t;

  typedef struct packed {
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [31:0] norm_w;
    logic        was_zero;
  } vn_out_t;

  localparam logic [31:0] RSQRT_MAGIC  = 32'h5f3759df;
  localparam logic [31:0] QNAN_BITS    = 32'h7fc00000;
  localparam logic [31:0] DFLT_NAN     = 32'hffc00000;
  localparam logic [31:0] FP_ONE       = 32'h3f800000;
  localparam logic [31:0] ONE_HALF     = 32'h3f000000;
  localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
  localparam logic [31:0] QUIET_BIT    = 32'h00400000;

  localparam int DIV_STEPS  = 5;
  localparam int DIV_ITERS  = 5;
  localparam int DIV_LAT    = DIV_ITERS + 2;
  localparam int PRE_STAGES = 8;
  localparam int NUM_STAGES = PRE_STAGES + 2 * DIV_LAT;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] != 23'h0);
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] == 23'h0);
  endfunction

  function automatic logic is_zero(input logic [31:0] a);
    return a[30:0] == 31'h0;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // m[25] leading one, m[24:2] fraction, m[1] guard, m[0] sticky
  function automatic logic [31:0] rnd_pack(input logic sign, input logic signed [11:0] e,
                                           input logic [25:0] m);
    logic [25:0]        mm;
    logic [25:0]        lost;
    logic signed [11:0] sh;
    logic [7:0]         ef;
    logic               inc;
    logic [30:0]        mag;
    if (e >= 12'sd255) return {sign, 8'hff, 23'h0};
    mm = m;
    ef = e[7:0];
    if (e <= 12'sd0) begin
      sh = 12'sd1 - e;
      ef = 8'h0;
      if (sh > 12'sd25) begin
        mm = {25'h0, |m};
      end else begin
        lost = m & ~(26'h3ffffff << sh[4:0]);
        mm = (m >> sh[4:0]) | {25'h0, |lost};
      end
    end
    inc = mm[1] & (mm[0] | mm[2]);
    mag = {ef, mm[24:2]} + {30'h0, inc};
    return {sign, mag};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic [7:0]         ea;
    logic [7:0]         eb;
    logic [47:0]        p;
    logic [5:0]         lz;
    logic signed [11:0] e;
    s = a[31] ^ b[31];
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) return DFLT_NAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hff, 23'h0};
    if (is_zero(a) || is_zero(b)) return {s, 31'h0};
    ea = (a[30:23] == 8'h0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'h0) ? 8'd1 : b[30:23];
    p  = {24'h0, a[30:23] != 8'h0, a[22:0]} * {24'h0, b[30:23] != 8'h0, b[22:0]};
    lz = lzc48(p);
    p  = p << lz;
    e  = $signed({4'h0, ea}) + $signed({4'h0, eb}) - 12'sd126 - $signed({6'h0, lz});
    return rnd_pack(s, e, {p[47:23], |p[22:0]});
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b,
                                       input logic sub);
    logic [31:0]        bn;
    logic [31:0]        bg;
    logic [31:0]        sm;
    logic [7:0]         e_bg;
    logic [7:0]         e_sm;
    logic [7:0]         d;
    logic [26:0]        m_bg;
    logic [26:0]        m_sm;
    logic [26:0]        lost;
    logic [27:0]        r;
    logic [5:0]         lz;
    logic signed [11:0] e;
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    bn = b ^ {sub, 31'h0};
    if (is_inf(a) && is_inf(bn) && (a[31] != bn[31])) return DFLT_NAN;
    if (is_inf(a)) return a;
    if (is_inf(bn)) return bn;
    if (is_zero(a) && is_zero(bn)) return {a[31] & bn[31], 31'h0};
    if (bn[30:0] > a[30:0]) begin
      bg = bn;
      sm = a;
    end else begin
      bg = a;
      sm = bn;
    end
    e_bg = (bg[30:23] == 8'h0) ? 8'd1 : bg[30:23];
    e_sm = (sm[30:23] == 8'h0) ? 8'd1 : sm[30:23];
    d    = e_bg - e_sm;
    m_bg = {bg[30:23] != 8'h0, bg[22:0], 3'b000};
    m_sm = {sm[30:23] != 8'h0, sm[22:0], 3'b000};
    if (d >= 8'd27) begin
      m_sm = {26'h0, |m_sm};
    end else begin
      lost = m_sm & ~(27'h7ffffff << d[4:0]);
      m_sm = (m_sm >> d[4:0]) | {26'h0, |lost};
    end
    if (bg[31] == sm[31]) r = {1'b0, m_bg} + {1'b0, m_sm};
    else r = {1'b0, m_bg} - {1'b0, m_sm};
    if (r == 28'h0) return 32'h0;
    lz = lzc48({r, 20'h0});
    r  = r << lz;
    e  = $signed({4'h0, e_bg}) + 12'sd1 - $signed({6'h0, lz});
    return rnd_pack(bg[31], e, {r[27:3], |r[2:0]});
  endfunction

endpackage

`default_nettype wire

// ===== src/vn_div.sv =====
// pipelined single precision divider; its input, iteration and output registers advance only while en_i is high
// depends on vn_pkg for the rounding helper and special value tests
`default_nettype none

module vn_div import vn_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic      [31:0] quo_o
);

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [11:0] exp;
    logic [25:0]        rem;
    logic [23:0]        dvs;
    logic [24:0]        q;
  } div_st_t;

  div_st_t     st_q [DIV_ITERS+1];
  div_st_t     pre_d;
  logic [31:0] quo_q;

  function automatic div_st_t div_step(input div_st_t s);
    div_st_t r;
    r = s;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (r.rem >= {2'b00, r.dvs}) begin
        r.rem = r.rem - {2'b00, r.dvs};
        r.q   = {r.q[23:0], 1'b1};
      end else begin
        r.q = {r.q[23:0], 1'b0};
      end
      r.rem = {r.rem[24:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    logic [23:0] ma;
    logic [23:0] mb;
    logic [5:0]  lza;
    logic [5:0]  lzb;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic        s;
    s   = num_i[31] ^ den_i[31];
    ma  = {num_i[30:23] != 8'h0, num_i[22:0]};
    mb  = {den_i[30:23] != 8'h0, den_i[22:0]};
    ea  = (num_i[30:23] == 8'h0) ? 8'd1 : num_i[30:23];
    eb  = (den_i[30:23] == 8'h0) ? 8'd1 : den_i[30:23];
    lza = lzc48({ma, 24'h0});
    lzb = lzc48({mb, 24'h0});
    ma  = ma << lza;
    mb  = mb << lzb;
    pre_d.sign     = s;
    pre_d.dvs      = mb;
    pre_d.q        = '0;
    pre_d.spec     = 1'b1;
    pre_d.spec_val = {s, 31'h0};
    pre_d.exp      = $signed({4'h0, ea}) - $signed({6'h0, lza}) - $signed({4'h0, eb})
                     + $signed({6'h0, lzb}) + 12'sd127;
    pre_d.rem      = {2'b00, ma};
    if (ma < mb) begin
      pre_d.rem = {1'b0, ma, 1'b0};
      pre_d.exp = pre_d.exp - 12'sd1;
    end
    if (is_zero(den_i)) begin
      if (is_nan(num_i)) pre_d.spec_val = num_i | QUIET_BIT;
      else if (is_zero(num_i)) pre_d.spec_val = QNAN_BITS;
      else pre_d.spec_val = {s, 8'hff, 23'h0};
    end else if (is_nan(num_i)) begin
      pre_d.spec_val = num_i | QUIET_BIT;
    end else if (is_nan(den_i)) begin
      pre_d.spec_val = den_i | QUIET_BIT;
    end else if (is_inf(num_i) && is_inf(den_i)) begin
      pre_d.spec_val = DFLT_NAN;
    end else if (is_inf(num_i)) begin
      pre_d.spec_val = {s, 8'hff, 23'h0};
    end else if (is_inf(den_i) || is_zero(num_i)) begin
      pre_d.spec_val = {s, 31'h0};
    end else begin
      pre_d.spec = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= pre_d;
    end
  end

  for (genvar g = 1; g <= DIV_ITERS; g++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= div_step(st_q[g-1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= st_q[DIV_ITERS].spec ? st_q[DIV_ITERS].spec_val :
               rnd_pack(st_q[DIV_ITERS].sign, st_q[DIV_ITERS].exp,
                        {st_q[DIV_ITERS].q, st_q[DIV_ITERS].rem != 26'h0});
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ===== src/vector_normalize_top.sv =====
// throughput: one vector per cycle when not stalled; eight float stages, then two levels of seven stage dividers
// a stall at the output holds every stage; input ready drops only then
// reset clears the stage valid bits only, datapath registers are not reset
// depends on vn_pkg, vn_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module vector_normalize_top import vn_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire vn_in_t  in_data_i,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output vn_out_t      out_data_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i
);

  typedef struct packed {
    logic [2:0]       size;
    logic             zero;
    logic [3:0][31:0] comp;
  } side_t;

  logic                  en;
  logic [NUM_STAGES-1:0] vld_q;
  side_t                 side_q [NUM_STAGES];
  side_t                 side_d;
  logic [3:0][31:0]      sq_q;
  logic [31:0]           s01_q, zw_q, sq2_q, s_q, x2_q;
  logic [31:0]           y0_q [4];
  logic [31:0]           t5_q, t6_q, t7_q, y_q;
  logic [31:0]           len;
  logic [3:0][31:0]      quo;

  assign en         = !vld_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    side_d.comp = {in_data_i.comp_w, in_data_i.comp_z, in_data_i.comp_y, in_data_i.comp_x};
    if (in_data_i.vec_size < 3'd2) side_d.size = 3'd2;
    else if (in_data_i.vec_size > 3'd4) side_d.size = 3'd4;
    else side_d.size = in_data_i.vec_size;
    side_d.zero = is_zero(in_data_i.comp_x) && is_zero(in_data_i.comp_y)
                  && (side_d.size < 3'd3 || is_zero(in_data_i.comp_z))
                  && (side_d.size < 3'd4 || is_zero(in_data_i.comp_w));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < NUM_STAGES; i++) side_q[i] <= side_q[i-1];
      for (int i = 0; i < 4; i++) sq_q[i] <= fmul(side_d.comp[i], side_d.comp[i]);
      s01_q <= fadd(sq_q[0], sq_q[1], 1'b0);
      zw_q  <= fadd(sq_q[2], sq_q[3], 1'b0);
      sq2_q <= sq_q[2];
      s_q   <= (side_q[1].size == 3'd2) ? s01_q :
               fadd(s01_q, (side_q[1].size == 3'd3) ? sq2_q : zw_q, 1'b0);
      x2_q  <= fmul(s_q, ONE_HALF);
      y0_q[0] <= RSQRT_MAGIC - {s_q[31], s_q[31:1]};
      y0_q[1] <= y0_q[0];
      y0_q[2] <= y0_q[1];
      y0_q[3] <= y0_q[2];
      t5_q  <= fmul(x2_q, y0_q[0]);
      t6_q  <= fmul(t5_q, y0_q[1]);
      t7_q  <= fadd(THREE_HALVES, t6_q, 1'b1);
      y_q   <= fmul(y0_q[3], t7_q);
    end
  end

  vn_div u_len_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (FP_ONE),
    .den_i (y_q),
    .quo_o (len)
  );

  for (genvar g = 0; g < 4; g++) begin : g_comp_div
    vn_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (side_q[PRE_STAGES+DIV_LAT-1].comp[g]),
      .den_i (len),
      .quo_o (quo[g])
    );
  end

  always_comb begin
    logic [3:0][31:0] res;
    for (int i = 0; i < 4; i++) begin
      res[i] = (side_q[NUM_STAGES-1].zero || (3'(i) >= side_q[NUM_STAGES-1].size)) ?
               side_q[NUM_STAGES-1].comp[i] : quo[i];
    end
    out_data_o.norm_x   = res[0];
    out_data_o.norm_y   = res[1];
    out_data_o.norm_z   = res[2];
    out_data_o.norm_w   = res[3];
    out_data_o.was_zero = side_q[NUM_STAGES-1].zero;
  end

  assign out_valid_o = vld_q[NUM_STAGES-1];

  `VN_ASSERT(a_ready_only_on_stall, clk_i, rst_ni, !in_ready_o |-> out_valid_o && !out_ready_i)
  `VN_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(out_data_o))
  `VN_ASSERT_NEXT(a_valid_advances, clk_i, rst_ni, en && vld_q[NUM_STAGES-2], out_valid_o)

endmodule

`default_nettype wire
